// ----- design/orf_pkg.sv -----
package orf_pkg;

  localparam int WORD_W    = 64;
  localparam int MAX_WORDS = 4;
  localparam int FILL_W    = 7;
  localparam int VERDICT_W = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [FILL_W-1:0]    CAPACITY_RESET = FILL_W'(64);
  localparam logic                 REG_CAPACITY   = 1'b0;

  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_REPLAY = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FULL   = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SEARCH,
    SEQ_DECIDE
  } orf_state_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [FILL_W-1:0]    entries_used;
  } orf_result_t;

endpackage

// ----- design/orf_table.sv -----
module orf_table import orf_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 256,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/orf_seq.sv -----
module orf_seq import orf_pkg::*; #(
  parameter int TABLE_DEPTH  = 64,
  parameter int DIGEST_WORDS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [MAX_WORDS-1:0][WORD_W-1:0]  start_words,
  input  logic [WORD_W-1:0]                 start_epoch,
  input  logic [FILL_W-1:0]                 capacity,
  output logic                              done,
  output orf_result_t                       result
);

  localparam int ROW_W = DIGEST_WORDS * WORD_W;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int XW    = (AW > FILL_W) ? AW : FILL_W;
  localparam int FILL_MAX = (1 << FILL_W) - 1;
  localparam logic [FILL_W-1:0] LIMIT_MAX =
    FILL_W'((TABLE_DEPTH > FILL_MAX) ? FILL_MAX : TABLE_DEPTH);

  orf_state_t        state_r, state_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [WORD_W-1:0] last_epoch_r, last_epoch_nxt;
  logic [ROW_W-1:0]  digest_r, digest_nxt;
  logic [WORD_W-1:0] epoch_r, epoch_nxt;

  logic [FILL_W-1:0] limit;
  logic              issue;
  logic              hit;
  logic              mem_we;
  logic              mem_re;
  logic [XW-1:0]     idx_ext;
  logic [XW-1:0]     fill_ext;
  logic [ROW_W-1:0]  rdata;

  assign limit    = (capacity > LIMIT_MAX) ? LIMIT_MAX : capacity;
  assign issue    = (idx_r < fill_r);
  assign hit      = pend_r && (rdata == digest_r);
  assign idx_ext  = XW'(idx_r);
  assign fill_ext = XW'(fill_r);

  orf_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ROW_W),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_ext[AW-1:0]),
    .wdata (digest_r),
    .re    (mem_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_IDLE;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      fill_r       <= '0;
      last_epoch_r <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      fill_r       <= fill_nxt;
      last_epoch_r <= last_epoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digest_r <= digest_nxt;
    epoch_r  <= epoch_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    fill_nxt       = fill_r;
    last_epoch_nxt = last_epoch_r;
    digest_nxt     = digest_r;
    epoch_nxt      = epoch_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    done           = 1'b0;
    result.verdict      = VERDICT_FULL;
    result.entries_used = fill_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          digest_nxt = start_words[DIGEST_WORDS-1:0];
          epoch_nxt  = start_epoch;
          if (start_epoch != last_epoch_r) begin
            fill_nxt = '0;
          end
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = SEQ_SEARCH;
        end
      end
      SEQ_SEARCH: begin
        mem_re   = issue;
        pend_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + FILL_W'(1);
        end
        if (hit) begin
          done           = 1'b1;
          result.verdict = VERDICT_REPLAY;
          pend_nxt       = 1'b0;
          state_nxt      = SEQ_IDLE;
        end else if (!issue && !pend_r) begin
          state_nxt = SEQ_DECIDE;
        end
      end
      SEQ_DECIDE: begin
        done      = 1'b1;
        state_nxt = SEQ_IDLE;
        if (fill_r < limit) begin
          mem_we              = 1'b1;
          fill_nxt            = fill_r + FILL_W'(1);
          last_epoch_nxt      = epoch_r;
          result.verdict      = VERDICT_ACCEPT;
          result.entries_used = fill_nxt;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

endmodule

// ----- design/otp_replay_filter.sv -----
// Replay filter for one-time-password digests. Each transfer on the input
// channel carries a digest and its time epoch; a new epoch empties the table
// of used digests, the stored entries are then searched for the digest, and
// the block answers accept (digest stored), replay or table full, together
// with the fill count. The search reads the digest memory through its single
// read port, one stored entry per cycle, and the result is registered before
// it is offered; the next item is taken once that result has been
// transferred.
// The table needs no clearing after reset, and the capacity register may be
// written only while no item is in progress.
module otp_replay_filter import orf_pkg::*; #(
  parameter int TABLE_DEPTH  = 64,
  parameter int DIGEST_WORDS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_digest_word0,
  input  logic [WORD_W-1:0]    in_digest_word1,
  input  logic [WORD_W-1:0]    in_digest_word2,
  input  logic [WORD_W-1:0]    in_digest_word3,
  input  logic [WORD_W-1:0]    in_epoch,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERDICT_W-1:0] out_verdict,
  output logic [FILL_W-1:0]    out_entries_used,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  orf_result_t       result_r, result_nxt;
  logic [FILL_W-1:0] capacity_r, capacity_nxt;

  logic        in_take;
  logic        cfg_write;
  logic        done;
  orf_result_t result;

  assign in_stall  = busy_r || out_valid_r;
  assign in_take   = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  orf_seq #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .DIGEST_WORDS (DIGEST_WORDS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_take),
    .start_words ({in_digest_word3, in_digest_word2, in_digest_word1, in_digest_word0}),
    .start_epoch (in_epoch),
    .capacity    (capacity_r),
    .done        (done),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAPACITY_RESET;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      capacity_r  <= capacity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    capacity_nxt  = capacity_r;
    if (in_take) begin
      busy_nxt = 1'b1;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      result_nxt    = result;
    end
    if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
      capacity_nxt = pwdata[FILL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(capacity_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = result_r.verdict;
  assign out_entries_used = result_r.entries_used;

endmodule
